FILE: hw/rtl/cau_pkg.sv
// Package for the complex arithmetic unit: operation and status codes,
// pipeline widths and the side-band record type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_NEG   = 2'd1,
    ACT_MUL   = 2'd2,
    ACT_RECIP = 2'd3
  } cau_action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2,
    ST_RSVD = 2'd3
  } cau_status_e;

  localparam int unsigned QuoW   = 25;
  localparam int unsigned DenW   = 32;
  localparam int unsigned MagW   = 16;
  localparam int unsigned RemW   = DenW + 1;

  typedef struct packed {
    logic        recip;
    logic        neg_re;
    logic        neg_im;
    logic [31:0] re;
    logic [31:0] im;
    cau_status_e status;
  } cau_side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cau_if.sv
// Valid/ready channel interfaces for the complex arithmetic unit.
// Depends on nothing; carries operand and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface cau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] a_real;
  logic [15:0] a_imag;
  logic [15:0] b_real;
  logic [15:0] b_imag;
  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_real;
  logic [31:0] result_imag;
  logic [1:0]  status;
  modport source (output valid, result_real, result_imag, status, input ready);
  modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cau_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Computes (num << 24) / den for unsigned operands; uses cau_pkg widths.
`timescale 1ns / 1ps
`default_nettype none
module cau_divider (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [cau_pkg::MagW-1:0]  num_i,
  input  wire logic [cau_pkg::DenW-1:0]  den_i,
  output logic      [cau_pkg::QuoW-1:0]  quo_o
);

  logic [cau_pkg::RemW-1:0] rem_q [cau_pkg::QuoW+1];
  logic [cau_pkg::DenW-1:0] den_q [cau_pkg::QuoW+1];
  logic [cau_pkg::QuoW-1:0] bits_q [cau_pkg::QuoW+1];
  logic [cau_pkg::QuoW-1:0] quo_q [cau_pkg::QuoW+1];

  // Dividend bits: high part num>>1 seeds the remainder, rest shift in.
  always_comb begin
    rem_q[0]  = {{(cau_pkg::RemW-cau_pkg::MagW+1){1'b0}}, num_i[cau_pkg::MagW-1:1]};
    den_q[0]  = den_i;
    bits_q[0] = {num_i[0], {(cau_pkg::QuoW-1){1'b0}}};
    quo_q[0]  = '0;
  end

  for (genvar k = 0; k < cau_pkg::QuoW; k++) begin : g_stage
    logic [cau_pkg::RemW-1:0] shf;
    logic [cau_pkg::RemW-1:0] dif;
    logic                     take;
    assign shf  = {rem_q[k][cau_pkg::RemW-2:0], bits_q[k][cau_pkg::QuoW-1]};
    assign dif  = shf - {1'b0, den_q[k]};
    assign take = (shf >= {1'b0, den_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? dif : shf;
        den_q[k+1]  <= den_q[k];
        bits_q[k+1] <= {bits_q[k][cau_pkg::QuoW-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][cau_pkg::QuoW-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[cau_pkg::QuoW];

endmodule
`default_nettype wire

FILE: hw/rtl/complex_arith_unit_top.sv
// Top level of the complex arithmetic unit: products, sums, divider, output.
// Depends on cau_pkg, cau_if and cau_divider.
//
//   channel | dir | beat
//   in_i    | in  | action, a_real, a_imag, b_real, b_imag (Q8.8)
//   out_o   | out | result_real, result_imag (Q16.16), status
//
// One beat in per cycle while the output is not stalled; 28 register stages
// (products, sums, 25 divider stages, output register), and every operation
// passes through all of them.
// The divider's one-bit-per-stage chain sets the depth.
// Reset clears the valid bits only. A stalled output freezes the whole pipe.
`timescale 1ns / 1ps
`default_nettype none
module complex_arith_unit_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);

  logic adv;
  logic v1_q, v2_q, vo_q;
  logic [cau_pkg::QuoW-1:0] vd_q;

  cau_pkg::cau_action_e act1_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;
  logic signed [15:0] ar1_q, ai1_q;
  logic signed [31:0] add_re_q, add_im_q, neg_re_q, neg_im_q;

  cau_pkg::cau_side_t side2_q;
  logic [cau_pkg::MagW-1:0] mag_r2_q, mag_i2_q;
  logic [cau_pkg::DenW-1:0] den2_q;
  cau_pkg::cau_side_t side_q [cau_pkg::QuoW];

  logic [cau_pkg::QuoW-1:0] quo_r, quo_i;
  logic [31:0] res_re_q, res_im_q;
  cau_pkg::cau_status_e st_q;

  assign adv        = !vo_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: products and add/negate.
  logic signed [15:0] ar, ai, br, bi;
  logic signed [16:0] sum_r, sum_i;
  assign ar = in_i.a_real;
  assign ai = in_i.a_imag;
  assign br = in_i.b_real;
  assign bi = in_i.b_imag;
  assign sum_r = 17'(ar) + 17'(br);
  assign sum_i = 17'(ai) + 17'(bi);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act1_q   <= cau_pkg::cau_action_e'(in_i.action);
      p_rr_q   <= 32'(ar) * 32'(br);
      p_ii_q   <= 32'(ai) * 32'(bi);
      p_ri_q   <= 32'(ar) * 32'(bi);
      p_ir_q   <= 32'(br) * 32'(ai);
      sq_r_q   <= 32'(ar) * 32'(ar);
      sq_i_q   <= 32'(ai) * 32'(ai);
      ar1_q    <= ar;
      ai1_q    <= ai;
      add_re_q <= {{7{sum_r[16]}}, sum_r, 8'd0};
      add_im_q <= {{7{sum_i[16]}}, sum_i, 8'd0};
      neg_re_q <= -{{8{ar[15]}}, ar, 8'd0};
      neg_im_q <= -{{8{ai[15]}}, ai, 8'd0};
    end
  end

  // Stage 2: product sums, saturation, denominator, magnitudes.
  logic signed [32:0] m_re, m_im;
  logic [31:0] sat_re, sat_im;
  logic ovf_re, ovf_im;
  logic [cau_pkg::DenW-1:0] den;
  cau_pkg::cau_side_t side_d;

  assign m_re   = 33'(p_rr_q) - 33'(p_ii_q);
  assign m_im   = 33'(p_ri_q) + 33'(p_ir_q);
  assign ovf_re = m_re[32] != m_re[31];
  assign ovf_im = m_im[32] != m_im[31];
  assign sat_re = ovf_re ? (m_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : m_re[31:0];
  assign sat_im = ovf_im ? (m_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : m_im[31:0];
  assign den    = sq_r_q + sq_i_q;

  always_comb begin
    side_d        = '0;
    side_d.status = cau_pkg::ST_OK;
    case (act1_q)
      cau_pkg::ACT_ADD: begin
        side_d.re = add_re_q;
        side_d.im = add_im_q;
      end
      cau_pkg::ACT_NEG: begin
        side_d.re = neg_re_q;
        side_d.im = neg_im_q;
      end
      cau_pkg::ACT_MUL: begin
        side_d.re = sat_re;
        side_d.im = sat_im;
        if (ovf_re || ovf_im) side_d.status = cau_pkg::ST_SAT;
      end
      default: begin
        side_d.recip  = 1'b1;
        side_d.neg_re = ar1_q[15];
        side_d.neg_im = (ai1_q != 16'sd0) && !ai1_q[15];
        if (den == '0) side_d.status = cau_pkg::ST_DIV0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q  <= side_d;
      den2_q   <= den;
      mag_r2_q <= ar1_q[15] ? 16'(-ar1_q) : 16'(ar1_q);
      mag_i2_q <= ai1_q[15] ? 16'(-ai1_q) : 16'(ai1_q);
    end
  end

  // Divider stages with side-band delay line.
  cau_divider u_div_re (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (mag_r2_q),
    .den_i (den2_q),
    .quo_o (quo_r)
  );

  cau_divider u_div_im (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (mag_i2_q),
    .den_i (den2_q),
    .quo_o (quo_i)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side2_q;
      for (int k = 1; k < cau_pkg::QuoW; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Output register: apply reciprocal signs, zero a divide-by-zero result, else pass the side-band value.
  cau_pkg::cau_side_t last;
  logic [31:0] q_re, q_im;
  assign last = side_q[cau_pkg::QuoW-1];
  assign q_re = {{(32-cau_pkg::QuoW){1'b0}}, quo_r};
  assign q_im = {{(32-cau_pkg::QuoW){1'b0}}, quo_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= last.status;
      if (last.recip && last.status == cau_pkg::ST_DIV0) begin
        res_re_q <= '0;
        res_im_q <= '0;
      end else if (last.recip) begin
        res_re_q <= last.neg_re ? -q_re : q_re;
        res_im_q <= last.neg_im ? -q_im : q_im;
      end else begin
        res_re_q <= last.re;
        res_im_q <= last.im;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vd_q <= '0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      vd_q <= {vd_q[cau_pkg::QuoW-2:0], v2_q};
      vo_q <= vd_q[cau_pkg::QuoW-1];
    end
  end

  assign out_o.valid       = vo_q;
  assign out_o.result_real = res_re_q;
  assign out_o.result_imag = res_im_q;
  assign out_o.status      = st_q;

endmodule
`default_nettype wire
